FILE: src/bpl_pkg.sv
`default_nettype none

package bpl_pkg;

    // Field widths of the request and response channels.
    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int LEN_W = 7;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_POP_FRONT  = 3'd1;
    localparam op_t OP_PUSH_BACK  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_INSERT     = 3'd4;
    localparam op_t OP_DELETE     = 3'd5;
    localparam op_t OP_READ       = 3'd6;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        length;
    } result_t;

endpackage

`default_nettype wire

FILE: src/bpl_if.sv
`default_nettype none

interface bpl_req_if;
    import bpl_pkg::*;

    logic                    valid;
    logic                    ready;
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface bpl_rsp_if;
    import bpl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;

    modport source (output valid, output ok, output read_value, output length,
                    input ready);
    modport sink   (input valid, input ok, input read_value, input length,
                    output ready);
endinterface

`default_nettype wire

FILE: src/bpl_mem.sv
`default_nettype none

// Element store: one write port and one read port with registered read data.
module bpl_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);
    logic [WIDTH-1:0] cells [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/bpl_ctrl.sv
`default_nettype none

// Request sequencer: keeps the list as a ring in the element store, with a head
// pointer and a count, and moves elements one per cycle for insert and delete.
module bpl_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bpl_req_if.sink                           req,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output bpl_pkg::result_t                  res,
    output logic                              mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]       mem_wr_addr,
    output logic [bpl_pkg::VAL_W-1:0]         mem_wr_data,
    output logic                              mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]       mem_rd_addr,
    input  wire logic [bpl_pkg::VAL_W-1:0]    mem_rd_data
);
    import bpl_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [IW:0] CAP_EXT = (IW+1)'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    moves_reg, moves_next;
    logic             pend_reg, pend_next;
    logic             ins_reg, ins_next;
    logic             res_valid_reg, res_valid_next;
    logic [IW-1:0]    src_reg, src_next;
    logic [IW-1:0]    dst_reg, dst_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    result_t          res_reg, res_next;

    logic             full;
    logic             req_fire;
    logic [CMPW-1:0]  pos_c;
    logic [CMPW-1:0]  cnt_c;
    logic [IW-1:0]    head_inc;
    logic [IW-1:0]    head_dec;
    logic [LEN_W-1:0] len_up;
    logic [LEN_W-1:0] len_down;

    // Logical index to physical entry: one add and one conditional subtract.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [IW-1:0] idx);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= CAP_EXT)
        begin
            sum = sum - CAP_EXT;
        end
        return sum[IW-1:0];
    endfunction

    assign full     = (count_reg == CW'(CAPACITY));
    assign req.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign req_fire = req.valid && req.ready;
    assign pos_c    = CMPW'(req.position);
    assign cnt_c    = CMPW'(count_reg);
    assign head_inc = (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);
    assign head_dec = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - IW'(1);
    assign len_up   = LEN_W'(count_reg + CW'(1));
    assign len_down = LEN_W'(count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        moves_next     = moves_reg;
        pend_next      = 1'b0;
        ins_next       = ins_reg;
        res_valid_next = res_valid_reg && !res_ready;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = dst_reg;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = phys(head_reg, src_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next.ok         = 1'b0;
                    res_next.read_value = '0;
                    res_next.length     = LEN_W'(count_reg);
                    res_valid_next      = 1'b1;
                    unique case (req.operation)
                        OP_PUSH_FRONT:
                        begin
                            if (!full)
                            begin
                                head_next       = head_dec;
                                mem_wr_en       = 1'b1;
                                mem_wr_addr     = head_dec;
                                mem_wr_data     = req.value;
                                count_next      = count_reg + CW'(1);
                                res_next.ok     = 1'b1;
                                res_next.length = len_up;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next       = head_inc;
                                count_next      = count_reg - CW'(1);
                                res_next.ok     = 1'b1;
                                res_next.length = len_down;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (!full)
                            begin
                                mem_wr_en       = 1'b1;
                                mem_wr_addr     = phys(head_reg, IW'(count_reg));
                                mem_wr_data     = req.value;
                                count_next      = count_reg + CW'(1);
                                res_next.ok     = 1'b1;
                                res_next.length = len_up;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next      = count_reg - CW'(1);
                                res_next.ok     = 1'b1;
                                res_next.length = len_down;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (!full && (pos_c != '0) && (pos_c <= cnt_c))
                            begin
                                count_next = count_reg + CW'(1);
                                if (pos_c == cnt_c)
                                begin
                                    // Insert at the tail needs no moves.
                                    mem_wr_en       = 1'b1;
                                    mem_wr_addr     = phys(head_reg, IW'(count_reg));
                                    mem_wr_data     = req.value;
                                    res_next.ok     = 1'b1;
                                    res_next.length = len_up;
                                end
                                else
                                begin
                                    src_next       = IW'(count_reg - CW'(1));
                                    moves_next     = CW'(cnt_c - pos_c);
                                    pos_next       = IW'(req.position);
                                    val_next       = req.value;
                                    ins_next       = 1'b1;
                                    res_valid_next = 1'b0;
                                    state_next     = S_SHIFT;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if ((pos_c != '0) && (pos_c < cnt_c))
                            begin
                                count_next = count_reg - CW'(1);
                                if (pos_c + CMPW'(1) == cnt_c)
                                begin
                                    // Removing the last element needs no moves.
                                    res_next.ok     = 1'b1;
                                    res_next.length = len_down;
                                end
                                else
                                begin
                                    src_next       = IW'(pos_c + CMPW'(1));
                                    moves_next     = CW'(cnt_c - pos_c - CMPW'(1));
                                    ins_next       = 1'b0;
                                    res_valid_next = 1'b0;
                                    state_next     = S_SHIFT;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_c < cnt_c)
                            begin
                                mem_rd_en      = 1'b1;
                                mem_rd_addr    = phys(head_reg, IW'(req.position));
                                res_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            res_next.ok = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // Write back the element read in the previous cycle.
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = dst_reg;
                    mem_wr_data = mem_rd_data;
                end
                if (moves_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, src_reg);
                    pend_next   = 1'b1;
                    moves_next  = moves_reg - CW'(1);
                    if (ins_reg)
                    begin
                        dst_next = phys(head_reg, src_reg + IW'(1));
                        src_next = src_reg - IW'(1);
                    end
                    else
                    begin
                        dst_next = phys(head_reg, src_reg - IW'(1));
                        src_next = src_reg + IW'(1);
                    end
                end
                else if (ins_reg)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    res_next.ok         = 1'b1;
                    res_next.read_value = '0;
                    res_next.length     = LEN_W'(count_reg);
                    res_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_FILL:
            begin
                mem_wr_en           = 1'b1;
                mem_wr_addr         = phys(head_reg, pos_reg);
                mem_wr_data         = val_reg;
                res_next.ok         = 1'b1;
                res_next.read_value = '0;
                res_next.length     = LEN_W'(count_reg);
                res_valid_next      = 1'b1;
                state_next          = S_IDLE;
            end
            S_READ:
            begin
                res_next.ok         = 1'b1;
                res_next.read_value = mem_rd_data;
                res_next.length     = LEN_W'(count_reg);
                res_valid_next      = 1'b1;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            moves_reg     <= '0;
            pend_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            moves_reg     <= moves_next;
            pend_reg      <= pend_next;
            ins_reg       <= ins_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: src/bounded_positional_list.sv
// A response passes the sequencer's result register and then the response register; a read
// first passes S_READ, and an insert or delete that moves elements first passes S_SHIFT,
// and an insert then S_FILL. A new request is taken only when the sequencer is idle with
// its result handed on; the store moves one element per cycle through its write port.
// Reset: rst_n is asynchronous and active low; it empties the list and drops both response
// stages at once. The element store itself is not cleared, so no clearing pass follows reset.
`default_nettype none

module bounded_positional_list #(
    parameter int CAPACITY = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bpl_req_if.sink   req,
    bpl_rsp_if.source rsp
);
    import bpl_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    // The sequencer hands each finished result to its own staging register, from
    // which the response register below takes it. A new request can therefore be
    // accepted while an earlier response still waits on the response port.
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    logic             mem_wr_en;
    logic [IW-1:0]    mem_wr_addr;
    logic [VAL_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [IW-1:0]    mem_rd_addr;
    logic [VAL_W-1:0] mem_rd_data;

    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    bpl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // The list is held as a ring in this store; the sequencer owns both ports.
    bpl_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The response register is free when it is empty or is being emptied this cycle.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_reg.ok;
    assign rsp.read_value = out_reg.read_value;
    assign rsp.length     = out_reg.length;

endmodule

`default_nettype wire

FILE: src/bpl_checker.sv
`default_nettype none

module bpl_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic                           rsp_ok,
    input wire logic signed [bpl_pkg::VAL_W-1:0] rsp_read_value,
    input wire logic [bpl_pkg::LEN_W-1:0]      rsp_length
);
    import bpl_pkg::*;

    // Length carried by the last response that was taken.
    logic [LEN_W-1:0] last_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_len_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            last_len_reg <= rsp_length;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({rsp_ok, rsp_read_value, rsp_length}))
        else $error("response payload changed while stalled");

    a_reject_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> (rsp_length == last_len_reg) && (rsp_read_value == '0))
        else $error("rejected request changed the length or returned data");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ok |-> (rsp_length == last_len_reg)
                             || (rsp_length == last_len_reg + LEN_W'(1))
                             || (rsp_length + LEN_W'(1) == last_len_reg))
        else $error("length moved by more than one element");

endmodule

bind bounded_positional_list bpl_checker u_bpl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_read_value (rsp.read_value),
    .rsp_length     (rsp.length)
);

`default_nettype wire

FILE: tb/sv/bpl_list_checker.sv
module bpl_list_checker #(
    parameter int CAPACITY = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bpl_req_if        req,
    bpl_rsp_if        rsp,
    output int        failures,
    output int        outstanding,
    output int        list_len
);
    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;

    // Shadow copy of the list: element 0 is the front.
    logic signed [VAL_W-1:0] shadow_cells [CAPACITY];
    int                      shadow_count = 0;
    result_t                 awaited_results[$];
    result_t                 oldest;

    function automatic void open_gap(int at, logic signed [VAL_W-1:0] v);
        int i;
        for (i = shadow_count; i > at; i--)
            shadow_cells[i] = shadow_cells[i - 1];
        shadow_cells[at] = v;
        shadow_count++;
    endfunction

    function automatic void close_gap(int at);
        int i;
        for (i = at; i + 1 < shadow_count; i++)
            shadow_cells[i] = shadow_cells[i + 1];
        shadow_count--;
    endfunction

    // Applies one request to the shadow list and returns the response it must produce.
    function automatic result_t apply_list_request(op_t op, int pos,
                                                   logic signed [VAL_W-1:0] v);
        result_t r;
        logic    full;
        full         = (shadow_count >= CAPACITY);
        r.ok         = 1'b0;
        r.read_value = '0;
        unique case (op)
            OP_PUSH_FRONT:
                if (!full)
                begin
                    open_gap(0, v);
                    r.ok = 1'b1;
                end
            OP_POP_FRONT:
                if (shadow_count > 0)
                begin
                    close_gap(0);
                    r.ok = 1'b1;
                end
            OP_PUSH_BACK:
                if (!full)
                begin
                    open_gap(shadow_count, v);
                    r.ok = 1'b1;
                end
            OP_POP_BACK:
                if (shadow_count > 0)
                begin
                    shadow_count--;
                    r.ok = 1'b1;
                end
            OP_INSERT:
                if (!full && pos >= 1 && pos <= shadow_count)
                begin
                    open_gap(pos, v);
                    r.ok = 1'b1;
                end
            OP_DELETE:
                if (pos >= 1 && pos < shadow_count)
                begin
                    close_gap(pos);
                    r.ok = 1'b1;
                end
            OP_READ:
                if (pos < shadow_count)
                begin
                    r.read_value = shadow_cells[pos];
                    r.ok         = 1'b1;
                end
            default:
                r.ok = 1'b0;
        endcase
        r.length = LEN_W'(shadow_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            failures     = 0;
            awaited_results.delete();
        end
        else
        begin
            // Responses are matched first: a request taken at this edge cannot answer yet.
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("response with none expected: ok %0d, read_value %0d, length %0d",
                           rsp.ok, rsp.read_value, rsp.length);
                    failures++;
                end
                else
                begin
                    oldest = awaited_results[0];
                    awaited_results.delete(0);
                    if (rsp.ok !== oldest.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", oldest.ok, rsp.ok);
                        failures++;
                    end
                    if (rsp.read_value !== oldest.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               oldest.read_value, rsp.read_value);
                        failures++;
                    end
                    if (rsp.length !== oldest.length)
                    begin
                        $error("length: expected %0d, actual %0d", oldest.length, rsp.length);
                        failures++;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_results.insert(awaited_results.size(),
                                       apply_list_request(req.operation,
                                                          int'(req.position), req.value));
        end
        outstanding = awaited_results.size();
        list_len    = shadow_count;
    end

endmodule

FILE: tb/sv/tb_bounded_positional_list.sv
module tb_bounded_positional_list;
    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;

    localparam int  CAPACITY     = 64;
    localparam int  RANDOM_ITEMS = 1025;
    // From this request onwards neither side idles.
    localparam int  QUIET_FROM   = 900;
    localparam int  PHASE_LEN    = 100;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 80;
    // The operation field has one code with no meaning; the block must reject it.
    localparam op_t OP_UNKNOWN   = 3'd7;

    localparam logic signed [VAL_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int failures;
    int outstanding;
    int list_len;
    int cycle_count = 0;
    // One chance in this many of a stall burst on the response side; zero means none.
    int stall_odds  = 0;

    bpl_req_if req ();
    bpl_rsp_if rsp ();

    bounded_positional_list #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    bpl_list_checker #(
        .CAPACITY(CAPACITY)
    ) list_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .failures   (failures),
        .outstanding(outstanding),
        .list_len   (list_len)
    );

    always #5 clk = ~clk;

    // A hung block must not keep the simulation alive for ever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The response side is ready by default and now and then holds off for a burst. Ready is
    // assigned at the falling edge that starts a burst and at every one outside a burst.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall     = $urandom_range(1, 6);
                rsp.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Presents one request at the falling edge and holds it until the block takes it.
    // The task returns at the accepting rising edge, so a following request simply
    // keeps valid high at the next falling edge.
    task automatic issue_request(op_t op, logic [POS_W-1:0] pos,
                                 logic signed [VAL_W-1:0] val);
        @(negedge clk);
        req.valid     <= 1'b1;
        req.operation <= op;
        req.position  <= pos;
        req.value     <= val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Leaves the request channel empty for the given number of cycles.
    task automatic hold_off(int cycles);
        repeat (cycles) @(negedge clk) req.valid <= 1'b0;
    endtask

    initial
    begin
        int                      n;
        int                      kind;
        int                      gap_odds;
        int                      pick;
        op_t                     op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;

        req.valid     = 1'b0;
        req.operation = OP_PUSH_FRONT;
        req.position  = '0;
        req.value     = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part. On the empty list every pop, read, delete and insert must be
        // refused and the length must stay at zero.
        issue_request(OP_POP_FRONT, 7'd0, '0);
        issue_request(OP_POP_BACK, 7'd0, '0);
        issue_request(OP_READ, 7'd0, '0);
        issue_request(OP_DELETE, 7'd0, '0);
        issue_request(OP_INSERT, 7'd1, 32'sd1);
        issue_request(OP_INSERT, 7'd0, 32'sd1);

        // Build a short list out of the extreme values: after these the list reads
        // most negative, zero, most positive, minus one, alternating bits.
        issue_request(OP_PUSH_BACK, 7'd0, MOST_POSITIVE);
        issue_request(OP_PUSH_FRONT, 7'd0, MOST_NEGATIVE);
        issue_request(OP_PUSH_BACK, 7'd0, -32'sd1);
        issue_request(OP_INSERT, 7'd1, 32'sd0);
        issue_request(OP_INSERT, 7'd4, 32'sh5555_5555);

        // Insert one past the end, reads at both ends and just beyond, and the
        // largest position the field can carry.
        issue_request(OP_INSERT, 7'd6, 32'sd9);
        issue_request(OP_READ, 7'd0, '0);
        issue_request(OP_READ, 7'd4, '0);
        issue_request(OP_READ, 7'd5, '0);
        issue_request(OP_READ, 7'd127, '0);

        // Deleting the front by position is not allowed, nor is deleting at the count.
        issue_request(OP_DELETE, 7'd0, '0);
        issue_request(OP_DELETE, 7'd5, '0);
        issue_request(OP_DELETE, 7'd4, '0);
        issue_request(OP_DELETE, 7'd1, '0);

        // The undefined operation code, then popping down to nothing, the last pop
        // taking a sole element from the back.
        issue_request(OP_UNKNOWN, 7'd127, 32'shAAAA_AAAA);
        issue_request(OP_POP_FRONT, 7'd0, '0);
        issue_request(OP_POP_BACK, 7'd0, '0);
        issue_request(OP_POP_BACK, 7'd0, '0);
        issue_request(OP_PUSH_FRONT, 7'd127, 32'shAAAA_AAAA);

        // Let the block run dry before the random part begins.
        hold_off(1);
        while (outstanding != 0)
            @(negedge clk);

        // Random part. The run moves through phases that grow the list, churn it and
        // shrink it, so that it fills to capacity and empties again several times.
        // Positions mostly fall in or just beyond the current list.
        gap_odds = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                kind       = (n / PHASE_LEN) % 3;
                gap_odds   = ((n / PHASE_LEN) % 4 == 3) ? 0 : 4;
                stall_odds = ((n / PHASE_LEN) % 5 == 2) ? 0 : 4;
            end
            if (n >= QUIET_FROM)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end

            // Halfway through, the sender waits until every response is back.
            if (n == RANDOM_ITEMS / 2)
            begin
                hold_off(1);
                while (outstanding != 0)
                    @(negedge clk);
            end

            pick = $urandom_range(0, 9);
            if (kind == 0)
            begin
                if (pick < 3)
                    op = OP_PUSH_BACK;
                else if (pick < 5)
                    op = OP_PUSH_FRONT;
                else if (pick < 7)
                    op = OP_INSERT;
                else if (pick == 7)
                    op = OP_POP_FRONT;
                else if (pick == 8)
                    op = OP_DELETE;
                else
                    op = OP_READ;
            end
            else if (kind == 2)
            begin
                if (pick < 3)
                    op = OP_POP_BACK;
                else if (pick < 5)
                    op = OP_POP_FRONT;
                else if (pick < 7)
                    op = OP_DELETE;
                else if (pick == 7)
                    op = OP_PUSH_BACK;
                else if (pick == 8)
                    op = OP_INSERT;
                else
                    op = OP_READ;
            end
            else
                op = op_t'($urandom_range(0, 7));

            if ($urandom_range(0, 4) == 0)
                pos = POS_W'($urandom_range(0, 127));
            else
                pos = POS_W'($urandom_range(0, list_len + 1));

            case ($urandom_range(0, 7))
                0:       val = MOST_NEGATIVE;
                1:       val = MOST_POSITIVE;
                2:       val = '0;
                default: val = $urandom();
            endcase

            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                hold_off($urandom_range(1, 6));
            issue_request(op, pos, val);
        end

        // Wait for the last responses, then give the block time to show anything stray.
        hold_off(1);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
